[hdl/multi_slot_tick_timer_table_assert.svh]
// Assertion macros for the multi-slot tick timer table.
// Depends on nothing; included by the checker file.
`ifndef MULTI_SLOT_TICK_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_TICK_TIMER_TABLE_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define MSTT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MSTT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mstt_pkg.sv]
// Package for the multi-slot tick timer table: widths, codes and slot type.
// Depends on nothing.
`default_nettype none
package mstt_pkg;

  localparam int SLOT_W        = 5;
  localparam int REQ_W         = 2;
  localparam int DATA_W        = 8;
  localparam int NUM_SLOTS_DEF = 20;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 2'd0,
    REQ_SCHEDULE   = 2'd1,
    REQ_CANCEL     = 2'd2,
    REQ_CANCEL_ALL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_GRANTED     = 2'd0,
    KIND_FULL        = 2'd1,
    KIND_ZERO_PERIOD = 2'd2,
    KIND_EXPIRED     = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] repeats;
  } slot_t;

endpackage
`default_nettype wire

[hdl/mstt_req_if.sv]
// Request channel interface of the timer table.
// Depends on mstt_pkg.
`default_nettype none
interface mstt_req_if;
  import mstt_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] period_ticks;
  logic [DATA_W-1:0] repeat_count;
  logic [SLOT_W-1:0] cancel_slot;

  modport source (output valid, req_type, period_ticks, repeat_count, cancel_slot,
                  input ready);
  modport sink (input valid, req_type, period_ticks, repeat_count, cancel_slot,
                output ready);
endinterface
`default_nettype wire

[hdl/mstt_res_if.sv]
// Result channel interface of the timer table.
// Depends on mstt_pkg.
`default_nettype none
interface mstt_res_if;
  import mstt_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [SLOT_W-1:0] slot;
  logic              last;

  modport source (output valid, result_kind, slot, last, input ready);
  modport sink (input valid, result_kind, slot, last, output ready);
endinterface
`default_nettype wire

[hdl/multi_slot_tick_timer_table.sv]
// Top level of the multi-slot tick timer table: cell ring plus walk control.
// Depends on mstt_pkg, mstt_req_if, mstt_res_if and mstt_cell.
`default_nettype none
// The table keeps NUM_SLOTS timer slots in a ring of cells that rotates one
// place per cycle during a walk unless stalled. Every request transaction
// (tick, schedule, cancel one, cancel all) walks the whole ring once: slot k
// sits at the head cell on walk step k, where it is updated and written back
// into the tail of the ring. A transaction passes through an accept step,
// NUM_SLOTS walk steps and one finish step; the walk holds while an expiry
// waits on a busy result port, as does a finish step with a result. Results
// leave through a single output register, so the next request is taken while
// the last result still waits. A tick reports expired slots in ascending
// order with last set on the final one; a quiet tick and both cancels give no
// result; a schedule always gives exactly one result with last set.
// No clearing pass is needed after reset.
module multi_slot_tick_timer_table #(
  parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mstt_req_if.sink    req,
  mstt_res_if.source  res
);
  import mstt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Latched request.
  logic [REQ_W-1:0]  req_type_r;
  logic [DATA_W-1:0] period_r;
  logic [DATA_W-1:0] repeats_r;
  logic [SLOT_W-1:0] cancel_r;

  // Walk position and per-transaction bookkeeping.
  logic [IDX_W-1:0]  idx;
  logic              granted;
  logic [SLOT_W-1:0] grant_slot;
  logic              pend_valid;
  logic [SLOT_W-1:0] pend_slot;

  // Ring of cells.
  slot_t ring [NUM_SLOTS];
  logic  free [NUM_SLOTS];
  slot_t head;
  slot_t head_next;
  logic  shift;

  // Output register.
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [SLOT_W-1:0] out_slot;
  logic              out_last;
  logic              out_free;
  logic              out_load;
  logic [1:0]        load_kind;
  logic [SLOT_W-1:0] load_slot;
  logic              load_last;

  // Head-step decisions.
  logic              expire;
  logic              take_slot;
  logic              stall;
  logic [DATA_W-1:0] rem_dec;
  logic              fin_valid;
  logic [1:0]        fin_kind;
  logic [SLOT_W-1:0] fin_slot;
  logic              accept;

  // Build the ring: each cell takes from its upper neighbor, the tail takes
  // the updated head.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    slot_t d_in;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign d_in = head_next;
    end else begin : g_mid
      assign d_in = ring[i+1];
    end
    mstt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d_in  (d_in),
      .q     (ring[i]),
      .free  (free[i])
    );
  end

  assign head     = ring[0];
  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;
  assign rem_dec  = head.remaining - DATA_W'(1);

  // Update the slot at the head according to the latched request.
  always_comb begin
    head_next = head;
    expire    = 1'b0;
    take_slot = 1'b0;
    case (req_type_r)
      REQ_TICK: begin
        if (!free[0]) begin
          head_next.remaining = rem_dec;
          if (rem_dec == '0) begin
            expire = 1'b1;
            if (head.repeats == DATA_W'(1)) begin
              head_next.period = '0;
            end else begin
              if (head.repeats != '0) begin
                head_next.repeats = head.repeats - DATA_W'(1);
              end
              head_next.remaining = head.period;
            end
          end
        end
      end
      REQ_SCHEDULE: begin
        if (period_r != '0 && !granted && free[0]) begin
          take_slot           = 1'b1;
          head_next.period    = period_r;
          head_next.remaining = period_r;
          head_next.repeats   = repeats_r;
        end
      end
      REQ_CANCEL: begin
        if (cancel_r == SLOT_W'(idx)) begin
          head_next.period = '0;
        end
      end
      REQ_CANCEL_ALL: begin
        head_next.period = '0;
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  // Hold the walk when an earlier expiry must leave but the port is busy.
  assign stall = expire && pend_valid && !out_free;
  assign shift = (state == ST_WALK) && !stall;

  // Final result of the transaction.
  always_comb begin
    fin_valid = 1'b0;
    fin_kind  = KIND_GRANTED;
    fin_slot  = '0;
    case (req_type_r)
      REQ_SCHEDULE: begin
        fin_valid = 1'b1;
        if (period_r == '0) begin
          fin_kind = KIND_ZERO_PERIOD;
        end else if (granted) begin
          fin_kind = KIND_GRANTED;
          fin_slot = grant_slot;
        end else begin
          fin_kind = KIND_FULL;
        end
      end
      REQ_TICK: begin
        fin_valid = pend_valid;
        fin_kind  = KIND_EXPIRED;
        fin_slot  = pend_slot;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  // Choose what goes into the output register this cycle.
  always_comb begin
    out_load  = 1'b0;
    load_kind = fin_kind;
    load_slot = fin_slot;
    load_last = 1'b1;
    case (state)
      ST_WALK: begin
        out_load  = expire && pend_valid && out_free;
        load_kind = KIND_EXPIRED;
        load_slot = pend_slot;
        load_last = 1'b0;
      end
      ST_DONE: begin
        out_load = fin_valid && out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (shift && idx == LAST_IDX) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!fin_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request fields on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r <= req.req_type;
      period_r   <= req.period_ticks;
      repeats_r  <= req.repeat_count;
      cancel_r   <= req.cancel_slot;
    end
  end

  // Advance the walk; track the grant and the held-back expiry.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      granted    <= 1'b0;
      pend_valid <= 1'b0;
    end else if (accept) begin
      idx        <= '0;
      granted    <= 1'b0;
      pend_valid <= 1'b0;
    end else if (shift) begin
      idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      if (take_slot) begin
        granted <= 1'b1;
      end
      if (expire) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift && take_slot) begin
      grant_slot <= SLOT_W'(idx);
    end
    if (shift && expire) begin
      pend_slot <= SLOT_W'(idx);
    end
  end

  // Output register: load a result, or drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= load_kind;
      out_slot <= load_slot;
      out_last <= load_last;
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.slot        = out_slot;
  assign res.last        = out_last;

endmodule
`default_nettype wire

[hdl/mstt_cell.sv]
// One timer slot of the rotating ring: holds period, countdown and repeats.
// Depends on mstt_pkg.
`default_nettype none
module mstt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire mstt_pkg::slot_t d_in,
  output mstt_pkg::slot_t      q,
  output logic                 free
);
  import mstt_pkg::*;

  // Only the period carries reset; it marks the slot free.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.period <= '0;
    end else if (shift) begin
      q.period <= d_in.period;
    end
    if (shift) begin
      q.remaining <= d_in.remaining;
      q.repeats   <= d_in.repeats;
    end
  end

  assign free = (q.period == '0);

endmodule
`default_nettype wire

[hdl/mstt_check.sv]
// Port-level checker for the multi-slot tick timer table, with its bind.
// Depends on mstt_pkg and multi_slot_tick_timer_table_assert.svh.
`default_nettype none
`include "multi_slot_tick_timer_table_assert.svh"
module mstt_check #(
  parameter int NUM_SLOTS = mstt_pkg::NUM_SLOTS_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire logic                      res_valid,
  input wire logic                      res_ready,
  input wire logic [1:0]                res_kind,
  input wire logic [mstt_pkg::SLOT_W-1:0] res_slot,
  input wire logic                      res_last
);
  import mstt_pkg::*;

  `MSTT_ASSERT_RST(a_reset_quiet, clk, rst |=> !res_valid, "result valid after reset")
  `MSTT_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while busy")
  `MSTT_ASSERT(a_slot_range, clk, rst, res_valid |-> int'(res_slot) < NUM_SLOTS, "slot out of range")
  `MSTT_ASSERT(a_sched_last, clk, rst, res_valid && res_kind != KIND_EXPIRED |-> res_last, "schedule result not last")
  `MSTT_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_slot), "result dropped")

endmodule

bind multi_slot_tick_timer_table mstt_check #(.NUM_SLOTS(NUM_SLOTS)) u_mstt_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.result_kind),
  .res_slot  (res.slot),
  .res_last  (res.last)
);
`default_nettype wire
